FILE: sv/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error("forbidden condition");
`endif

FILE: sv/dedge_pkg.sv
package dedge_pkg;
	localparam int unsigned LIN_MAX = 24'hFFFFFF;
	localparam logic [31:0] EDGE_COLOR = 32'hFF000000;
	localparam logic [0:0] OP_PIXEL = 1'b0;
	localparam logic [0:0] OP_FLUSH = 1'b1;
	localparam logic [2:0] REG_NEAR = 3'd0;
	localparam logic [2:0] REG_FAR = 3'd1;
	localparam logic [2:0] REG_THR = 3'd2;
	localparam logic [2:0] REG_DIST = 3'd3;
	localparam logic [2:0] REG_WIDTH = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;

	typedef struct packed {
		logic [0:0]  opcode;
		logic [23:0] depth_sample;
		logic [31:0] pixel_color;
	} in_word_t;

	typedef struct packed {
		logic [31:0] out_color;
		logic        is_edge;
		logic [10:0] out_column;
		logic [10:0] out_row;
		logic        frame_done;
	} out_word_t;

	// front to back: one classified item
	typedef struct packed {
		logic        is_pixel;
		logic [23:0] lin;
		logic [31:0] color;
	} job_t;

	typedef struct packed {
		logic [15:0] near_plane;
		logic [15:0] far_plane;
		logic [19:0] edge_threshold;
		logic [3:0]  pixel_distance;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
	} cfg_t;
endpackage

FILE: sv/dedge_front.sv
// Accepts items and linearizes depth with a restoring divider, one quotient bit a cycle.
module dedge_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dedge_pkg::cfg_t      cfg,
	input  logic                 push,
	output logic                 full,
	input  dedge_pkg::in_word_t  word,
	output logic                 job_valid,
	input  logic                 job_ready,
	output dedge_pkg::job_t      job
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_OUT  = 3'b100
	} fstate_t;

	fstate_t     state_q;
	logic [4:0]  cnt_q;
	logic [48:0] rem_q;
	logic [41:0] den_q;
	logic [23:0] quo_q;
	logic        sat_q;
	logic        pix_q;
	logic [31:0] color_q;

	logic [31:0] nf;
	logic [41:0] den;
	logic [24:0] inv;
	logic [48:0] r0;
	logic [49:0] rsh;

	assign nf  = 32'(cfg.near_plane) * 32'(cfg.far_plane);
	assign inv = 25'h1000000 - 25'(word.depth_sample);
	assign den = 42'(cfg.far_plane) * 42'(inv) + 42'(cfg.near_plane) * 42'(word.depth_sample);
	assign r0  = 49'(nf) << 8;
	assign rsh = {rem_q, 1'b0};

	assign full      = (state_q != F_IDLE);
	assign job_valid = (state_q == F_OUT);
	always_comb begin
		job.is_pixel = pix_q;
		job.lin      = sat_q ? 24'(dedge_pkg::LIN_MAX) : quo_q;
		job.color    = color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						if (word.opcode == dedge_pkg::OP_PIXEL) begin
							state_q <= F_DIV;
							cnt_q   <= '0;
						end else begin
							state_q <= F_OUT;
						end
					end
				end
				F_DIV: begin
					if (cnt_q == 5'd23) state_q <= F_OUT;
					cnt_q <= cnt_q + 5'd1;
				end
				F_OUT: begin
					if (job_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			pix_q   <= (word.opcode == dedge_pkg::OP_PIXEL);
			color_q <= word.pixel_color;
			rem_q   <= r0;
			den_q   <= den;
			quo_q   <= '0;
			sat_q   <= (den == '0) || (42'(r0) >= den && r0[48:42] == '0) || (r0[48:42] != '0);
		end else if (state_q == F_DIV) begin
			if (rsh >= 50'(den_q)) begin
				rem_q <= 49'(rsh - 50'(den_q));
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= rsh[48:0];
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end
endmodule

FILE: sv/dedge_queue.sv
// Two-entry queue between front and back.
module dedge_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  dedge_pkg::job_t  wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output dedge_pkg::job_t  rd_data
);
	dedge_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

FILE: sv/dedge_back.sv
// Stores lines, tests readiness, reads five depth samples (center and neighbors) one per cycle, emits.
module dedge_back #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_DISTANCE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dedge_pkg::cfg_t      cfg,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  dedge_pkg::job_t      job,
	output logic                 empty,
	input  logic                 pop,
	output dedge_pkg::out_word_t res
);
	localparam int DROWS = 2 * MAX_DISTANCE + 1;
	localparam int CROWS = MAX_DISTANCE + 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int DSW = $clog2(DROWS);
	localparam int CSW = $clog2(CROWS);
	localparam int DAW = $clog2(DROWS * MAX_WIDTH);
	localparam int CAW = $clog2(CROWS * MAX_WIDTH);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_TEST = 6'b000010,
		B_RD   = 6'b000100,
		B_MAG  = 6'b001000,
		B_CMP  = 6'b010000,
		B_OUT  = 6'b100000
	} bstate_t;

	logic [23:0] dmem [DROWS * MAX_WIDTH];
	logic [31:0] cmem [CROWS * MAX_WIDTH];

	bstate_t     state_q;
	logic [11:0] in_col_q, in_row_q, em_col_q, em_row_q;
	logic [DSW-1:0] in_ds_q, em_ds_q;
	logic [CSW-1:0] in_cs_q, em_cs_q;
	logic [23:0] pend_q;
	logic [2:0]  rd_q;
	logic [23:0] dq_q, c_q, gx_q, gy_q;
	logic [31:0] col_q;
	logic [47:0] mx_q, my_q, thr_q;
	dedge_pkg::out_word_t res_q;
	logic        full_q;

	logic [12:0] w, h;
	logic [4:0]  d;
	logic [12:0] cr, cl, ku, kd, need_r;
	logic [24:0] need;
	logic [DSW:0] rs_sum;
	logic [DSW-1:0] rslot;
	logic [12:0] rcol;
	logic [23:0] diff;
	logic [DAW-1:0] dwr_addr, drd_addr;
	logic [CAW-1:0] cwr_addr, crd_addr;

	always_comb begin
		w = (cfg.frame_width == '0) ? 13'd1 :
			(13'(cfg.frame_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(cfg.frame_width);
		h = (cfg.frame_height == '0) ? 13'd1 :
			(cfg.frame_height > 12'd2048) ? 13'd2048 : 13'(cfg.frame_height);
		d = (cfg.pixel_distance == '0) ? 5'd1 :
			(5'(cfg.pixel_distance) > 5'(MAX_DISTANCE)) ? 5'(MAX_DISTANCE) : 5'(cfg.pixel_distance);
		cr = (13'(em_col_q) + 13'(d) < w - 13'd1) ? 13'(em_col_q) + 13'(d) : w - 13'd1;
		cl = (13'(em_col_q) >= 13'(d)) ? 13'(em_col_q) - 13'(d) : 13'd0;
		ku = (13'(em_row_q) < 13'(d)) ? 13'(em_row_q) : 13'(d);
		if (13'(em_row_q) < h - 13'd1) begin
			kd = (h - 13'd1 - 13'(em_row_q) < 13'(d)) ? h - 13'd1 - 13'(em_row_q) : 13'(d);
			need_r = '0;
			need = 25'(kd) * 25'(w);
		end else begin
			kd = '0;
			need_r = (cr > 13'(em_col_q)) ? cr - 13'(em_col_q) : 13'd0;
			need = 25'(need_r);
		end
		rs_sum = '0;
		rcol = 13'(em_col_q);
		case (rd_q)
			3'd1: rcol = cl;
			3'd2: rcol = cr;
			3'd3: rs_sum = (DSW+1)'(em_ds_q) + (DSW+1)'(DROWS) - (DSW+1)'(ku);
			3'd4: rs_sum = (DSW+1)'(em_ds_q) + (DSW+1)'(kd);
			default: ;
		endcase
		if (rd_q == 3'd3 || rd_q == 3'd4)
			rslot = (rs_sum >= (DSW+1)'(DROWS)) ? DSW'(rs_sum - (DSW+1)'(DROWS)) : DSW'(rs_sum);
		else
			rslot = em_ds_q;
		diff = (c_q > dq_q) ? c_q - dq_q : dq_q - c_q;
	end

	assign dwr_addr = DAW'(in_ds_q) * DAW'(MAX_WIDTH) + DAW'(in_col_q[CW-1:0]);
	assign drd_addr = DAW'(rslot) * DAW'(MAX_WIDTH) + DAW'(rcol[CW-1:0]);
	assign cwr_addr = CAW'(in_cs_q) * CAW'(MAX_WIDTH) + CAW'(in_col_q[CW-1:0]);
	assign crd_addr = CAW'(em_cs_q) * CAW'(MAX_WIDTH) + CAW'(em_col_q[CW-1:0]);

	assign job_ready = (state_q == B_IDLE);
	assign empty = !full_q;
	assign res = res_q;

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && job_valid && job.is_pixel) begin
			dmem[dwr_addr] <= job.lin;
			cmem[cwr_addr] <= job.color;
		end
		dq_q  <= dmem[drd_addr];
		col_q <= cmem[crd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			in_col_q <= '0; in_row_q <= '0; em_col_q <= '0; em_row_q <= '0;
			in_ds_q <= '0; em_ds_q <= '0; in_cs_q <= '0; em_cs_q <= '0;
			pend_q <= '0; rd_q <= '0; full_q <= 1'b0;
		end else begin
			if (full_q && pop && state_q != B_CMP) full_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q <= B_TEST;
						if (job.is_pixel) begin
							if (pend_q != '1) pend_q <= pend_q + 24'd1;
							if (in_col_q + 12'd1 >= 12'(w)) begin
								in_col_q <= '0;
								in_ds_q <= (in_ds_q == DSW'(DROWS - 1)) ? '0 : in_ds_q + 1'b1;
								in_cs_q <= (in_cs_q == CSW'(CROWS - 1)) ? '0 : in_cs_q + 1'b1;
								in_row_q <= (13'(in_row_q) + 13'd1 >= h) ? '0 : in_row_q + 12'd1;
							end else begin
								in_col_q <= in_col_q + 12'd1;
							end
						end
					end
				end
				B_TEST: begin
					if (pend_q != '0 && 25'(pend_q) > need) begin
						state_q <= B_RD;
						rd_q <= '0;
					end else begin
						state_q <= B_IDLE;
					end
				end
				B_RD: begin
					rd_q <= rd_q + 3'd1;
					if (rd_q == 3'd5) state_q <= B_MAG;
				end
				B_MAG: state_q <= B_CMP;
				B_CMP: begin
					if (!full_q || pop) begin
						state_q <= B_IDLE;
						full_q <= 1'b1;
						pend_q <= pend_q - 24'd1;
						if (13'(em_col_q) + 13'd1 >= w) begin
							em_col_q <= '0;
							em_ds_q <= (em_ds_q == DSW'(DROWS - 1)) ? '0 : em_ds_q + 1'b1;
							em_cs_q <= (em_cs_q == CSW'(CROWS - 1)) ? '0 : em_cs_q + 1'b1;
							em_row_q <= (13'(em_row_q) + 13'd1 >= h) ? '0 : em_row_q + 12'd1;
						end else begin
							em_col_q <= em_col_q + 12'd1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// rd_q n reads sample n, which lands in dq_q in the following cycle
	always_ff @(posedge clk) begin
		if (state_q == B_RD) begin
			case (rd_q)
				3'd1: c_q <= dq_q;
				3'd2: gx_q <= diff;
				3'd3: if (diff > gx_q) gx_q <= diff;
				3'd4: gy_q <= diff;
				3'd5: if (diff > gy_q) gy_q <= diff;
				default: ;
			endcase
		end
		if (state_q == B_MAG) begin
			mx_q  <= 48'(gx_q) * 48'(gx_q);
			my_q  <= 48'(gy_q) * 48'(gy_q);
			thr_q <= 48'(cfg.edge_threshold) * 48'(cfg.edge_threshold);
		end
		if (state_q == B_CMP && (!full_q || pop)) begin
			res_q.is_edge    <= (49'(mx_q) + 49'(my_q)) > 49'(thr_q);
			res_q.out_color  <= ((49'(mx_q) + 49'(my_q)) > 49'(thr_q)) ?
				dedge_pkg::EDGE_COLOR : col_q;
			res_q.out_column <= em_col_q[10:0];
			res_q.out_row    <= em_row_q[10:0];
			res_q.frame_done <= (13'(em_row_q) == h - 13'd1) && (13'(em_col_q) == w - 13'd1);
		end
	end
endmodule

FILE: sv/depth_edge_detector.sv
// channel | handshake           | payload
// in      | push / full         | in_word_t
// out     | pop / empty         | out_word_t
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
// A pixel holds the input through the serial divider and the hand-off, a flush only
// through the hand-off. For an emitted word the back runs five line store reads,
// squaring and compare; an item that emits nothing only passes the readiness test.
// Asynchronous active-low reset clears control; line stores are not cleared.
// A result waits in the output register; the back stalls while it is not popped.
`include "assert_macros.svh"
module depth_edge_detector #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_DISTANCE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  dedge_pkg::in_word_t  in_word,
	output logic                 empty,
	input  logic                 pop,
	output dedge_pkg::out_word_t out_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	dedge_pkg::cfg_t cfg_q;
	dedge_pkg::job_t fjob, bjob;
	logic fv, fr, bv, br;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{16'd256, 16'd1792, 20'd4915, 4'd3, 12'd1280, 12'd720};
		end else if (cfg_valid) begin
			case (cfg_index)
				dedge_pkg::REG_NEAR:   cfg_q.near_plane     <= cfg_data[15:0];
				dedge_pkg::REG_FAR:    cfg_q.far_plane      <= cfg_data[15:0];
				dedge_pkg::REG_THR:    cfg_q.edge_threshold <= cfg_data[19:0];
				dedge_pkg::REG_DIST:   cfg_q.pixel_distance <= cfg_data[3:0];
				dedge_pkg::REG_WIDTH:  cfg_q.frame_width    <= cfg_data[11:0];
				dedge_pkg::REG_HEIGHT: cfg_q.frame_height   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	dedge_front u_front (.clk, .arst_n, .cfg(cfg_q), .push, .full, .word(in_word),
		.job_valid(fv), .job_ready(fr), .job(fjob));
	dedge_queue u_queue (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fjob),
		.rd_valid(bv), .rd_ready(br), .rd_data(bjob));
	dedge_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_DISTANCE(MAX_DISTANCE)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .job_valid(bv), .job_ready(br), .job(bjob),
		.empty, .pop, .res(out_word));

	`ASSERT_CLK(a_edge_black, (!empty && out_word.is_edge) |-> (out_word.out_color == dedge_pkg::EDGE_COLOR))
	`ASSERT_CLK(a_out_holds, (!empty && !pop) |=> (!empty && $stable(out_word)))
	`ASSERT_NEVER(a_push_full, push && full && !$past(full))
endmodule
